@@ rtl/fccb_pkg.sv @@
// ----------------------------------------------------------------------------
// fccb_pkg
// Types and constants shared by the cluster chain block sequencer.
// ----------------------------------------------------------------------------
package fccb_pkg;

	localparam int CLUSTER_W   = 28;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [27:0] CHAIN_END = 28'h0ffffff8;
	localparam logic [31:0] CLUSTER_BASE = 32'd2;
	localparam int          LOG2_MIN = 7;
	localparam int          LOG2_MAX = 10;

	localparam logic [31:0] FAT_START_RST    = 32'd32;
	localparam logic [31:0] DATA_START_RST   = 32'd0;
	localparam logic [7:0]  CLUSTER_SIZE_RST = 8'd8;
	localparam logic [3:0]  ENTRIES_LOG2_RST = 4'd7;

	typedef enum logic [1:0] {
		ACT_SEEK  = 2'd0,
		ACT_NEXT  = 2'd1,
		ACT_REPLY = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		KIND_DATA      = 3'd0,
		KIND_LOAD      = 3'd1,
		KIND_ENTRY_REQ = 3'd2,
		KIND_END       = 3'd3,
		KIND_SEEK_DONE = 3'd4,
		KIND_ERROR     = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		OP_DATA,
		OP_LOAD_SEEK,
		OP_SEEK,
		OP_ENTRY_REQ,
		OP_END,
		OP_ERROR
	} op_t;

	typedef enum logic [1:0] {
		REG_FAT_START    = 2'd0,
		REG_DATA_START   = 2'd1,
		REG_CLUSTER_SIZE = 2'd2,
		REG_ENTRIES_LOG2 = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [31:0] fat_start;
		logic [31:0] data_start;
		logic [7:0]  cluster_size;
		logic [3:0]  entries_log2;
	} cfg_t;

	typedef struct packed {
		op_t                  op;
		logic [CLUSTER_W-1:0] cluster;
		logic [7:0]           blk_old;
		logic [7:0]           block_now;
		logic [31:0]          tb;
		logic [9:0]           idx;
	} cmd_t;

	typedef struct packed {
		kind_t                kind;
		logic [31:0]          lba;
		logic [9:0]           idx;
		logic [CLUSTER_W-1:0] cluster;
		logic [7:0]           blk;
		logic                 last;
	} res_t;

endpackage

@@ rtl/fccb_front.sv @@
// ----------------------------------------------------------------------------
// fccb_front
// Accepts items, updates the chain state and queues one command per item.
// ----------------------------------------------------------------------------
module fccb_front #(
	parameter int CLUSTER_BITS = 28
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fccb_pkg::cfg_t                       cfg,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           action,
	input  logic [27:0]                          cluster_number,
	input  logic [7:0]                           block_in_cluster,
	input  logic [31:0]                          fat_entry,
	input  logic                                 q_full,
	output logic                                 push,
	output fccb_pkg::cmd_t                       cmd
);

	localparam int KEEP = (CLUSTER_BITS < fccb_pkg::CLUSTER_W) ?
		CLUSTER_BITS : fccb_pkg::CLUSTER_W;
	localparam logic [fccb_pkg::CLUSTER_W-1:0] CL_MASK =
		fccb_pkg::CLUSTER_W'((64'd1 << KEEP) - 64'd1);

	logic [fccb_pkg::CLUSTER_W-1:0] cur_cl_q;
	logic [7:0]                     blk_q;
	logic [31:0]                    cached_tb_q;
	logic                           cache_valid_q;
	logic                           awaiting_q;
	logic                           ended_q;

	logic [fccb_pkg::CLUSTER_W-1:0] entry;
	logic [fccb_pkg::CLUSTER_W-1:0] seek_cl;
	logic [fccb_pkg::CLUSTER_W-1:0] src_cl;
	logic [1:0]                     sel;
	logic [fccb_pkg::CLUSTER_W-1:0] shifted;
	logic [9:0]                     idx_mask;
	logic [31:0]                    tb;
	logic                           hit;
	logic                           do_seek;
	logic                           is_seek;
	logic                           is_reply;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	assign is_seek  = (action == fccb_pkg::ACT_SEEK);
	assign is_reply = (action == fccb_pkg::ACT_REPLY);
	assign entry    = fat_entry[fccb_pkg::CLUSTER_W-1:0];
	assign seek_cl  = (is_seek ? cluster_number : entry) & CL_MASK;
	assign src_cl   = (is_seek || is_reply) ? seek_cl : cur_cl_q;

	always_comb begin
		if (cfg.entries_log2 < 4'(fccb_pkg::LOG2_MIN)) begin
			sel = 2'd0;
		end else if (cfg.entries_log2 > 4'(fccb_pkg::LOG2_MAX)) begin
			sel = 2'd3;
		end else begin
			sel = 2'(cfg.entries_log2 - 4'(fccb_pkg::LOG2_MIN));
		end
	end

	always_comb begin
		unique case (sel)
			2'd0: begin
				shifted  = src_cl >> 7;
				idx_mask = 10'h07f;
			end
			2'd1: begin
				shifted  = src_cl >> 8;
				idx_mask = 10'h0ff;
			end
			2'd2: begin
				shifted  = src_cl >> 9;
				idx_mask = 10'h1ff;
			end
			default: begin
				shifted  = src_cl >> 10;
				idx_mask = 10'h3ff;
			end
		endcase
	end

	assign tb  = cfg.fat_start + 32'(shifted);
	assign hit = cache_valid_q && (cached_tb_q == tb);

	always_comb begin
		cmd.op        = fccb_pkg::OP_ERROR;
		cmd.cluster   = cur_cl_q;
		cmd.blk_old   = blk_q;
		cmd.block_now = blk_q;
		cmd.tb        = tb;
		cmd.idx       = cur_cl_q[9:0] & idx_mask;
		do_seek       = 1'b0;
		priority if (is_seek) begin
			do_seek = 1'b1;
		end else if (action == fccb_pkg::ACT_NEXT) begin
			priority if (awaiting_q) begin
				cmd.op = fccb_pkg::OP_ERROR;
			end else if (ended_q) begin
				cmd.op = fccb_pkg::OP_END;
			end else if (blk_q >= cfg.cluster_size) begin
				cmd.op = fccb_pkg::OP_ENTRY_REQ;
			end else begin
				cmd.op        = fccb_pkg::OP_DATA;
				cmd.block_now = blk_q + 8'd1;
			end
		end else if (is_reply && awaiting_q) begin
			if (entry == '0 || entry >= fccb_pkg::CHAIN_END) begin
				cmd.op = fccb_pkg::OP_END;
			end else begin
				do_seek = 1'b1;
			end
		end else begin
			cmd.op = fccb_pkg::OP_ERROR;
		end
		if (do_seek) begin
			cmd.op        = hit ? fccb_pkg::OP_SEEK : fccb_pkg::OP_LOAD_SEEK;
			cmd.cluster   = seek_cl;
			cmd.block_now = is_seek ? block_in_cluster : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_cl_q      <= '0;
			blk_q         <= '0;
			cached_tb_q   <= '0;
			cache_valid_q <= 1'b0;
			awaiting_q    <= 1'b0;
			ended_q       <= 1'b0;
		end else if (push) begin
			cur_cl_q <= cmd.cluster;
			blk_q    <= cmd.block_now;
			if (do_seek) begin
				awaiting_q <= 1'b0;
				ended_q    <= 1'b0;
				if (!hit) begin
					cached_tb_q   <= tb;
					cache_valid_q <= 1'b1;
				end
			end else if (cmd.op == fccb_pkg::OP_ENTRY_REQ) begin
				awaiting_q <= 1'b1;
			end else if (is_reply && cmd.op == fccb_pkg::OP_END) begin
				awaiting_q <= 1'b0;
				ended_q    <= 1'b1;
			end
		end
	end

endmodule

@@ rtl/fccb_queue.sv @@
// ----------------------------------------------------------------------------
// fccb_queue
// Small command queue between the front and the back.
// ----------------------------------------------------------------------------
module fccb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fccb_pkg::cmd_t push_cmd,
	output logic           full,
	output logic           q_valid,
	input  logic           pop,
	output fccb_pkg::cmd_t head
);

	localparam int DEPTH = fccb_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	fccb_pkg::cmd_t mem [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign q_valid = (count_q != '0);
	assign head    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

@@ rtl/fccb_back.sv @@
// ----------------------------------------------------------------------------
// fccb_back
// Executes queued commands: address multiply, then result expansion into
// an output register.
// ----------------------------------------------------------------------------
module fccb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  fccb_pkg::cfg_t cfg,
	input  logic           q_valid,
	output logic           q_pop,
	input  fccb_pkg::cmd_t q_cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output fccb_pkg::res_t res
);

	fccb_pkg::cmd_t cmd_s1;
	logic [31:0]    prod_s1;
	logic           valid_s1;
	logic           phase_q;
	logic           out_valid_q;
	fccb_pkg::res_t res_q;

	logic           out_can;
	logic           emit;
	logic           two_first;
	logic           s1_free;
	fccb_pkg::res_t nxt;

	assign out_can   = !out_valid_q || out_ready;
	assign emit      = valid_s1 && out_can;
	assign two_first = (cmd_s1.op == fccb_pkg::OP_LOAD_SEEK) && !phase_q;
	assign s1_free   = !valid_s1 || (emit && !two_first);
	assign q_pop     = q_valid && s1_free;

	always_comb begin
		nxt.kind    = fccb_pkg::KIND_ERROR;
		nxt.lba     = '0;
		nxt.idx     = '0;
		nxt.cluster = cmd_s1.cluster;
		nxt.blk     = cmd_s1.block_now;
		nxt.last    = 1'b1;
		unique case (cmd_s1.op)
			fccb_pkg::OP_DATA: begin
				nxt.kind = fccb_pkg::KIND_DATA;
				nxt.lba  = cfg.data_start + prod_s1 + 32'(cmd_s1.blk_old);
			end
			fccb_pkg::OP_LOAD_SEEK: begin
				if (!phase_q) begin
					nxt.kind = fccb_pkg::KIND_LOAD;
					nxt.lba  = cmd_s1.tb;
					nxt.last = 1'b0;
				end else begin
					nxt.kind = fccb_pkg::KIND_SEEK_DONE;
				end
			end
			fccb_pkg::OP_SEEK: begin
				nxt.kind = fccb_pkg::KIND_SEEK_DONE;
			end
			fccb_pkg::OP_ENTRY_REQ: begin
				nxt.kind = fccb_pkg::KIND_ENTRY_REQ;
				nxt.lba  = cmd_s1.tb;
				nxt.idx  = cmd_s1.idx;
			end
			fccb_pkg::OP_END: begin
				nxt.kind = fccb_pkg::KIND_END;
			end
			default: begin
				nxt.kind = fccb_pkg::KIND_ERROR;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_s1  <= q_cmd;
			prod_s1 <= (32'(q_cmd.cluster) - fccb_pkg::CLUSTER_BASE) * 32'(cfg.cluster_size);
		end
		if (emit) begin
			res_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= q_valid;
			end
			if (emit) begin
				phase_q <= two_first;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

@@ rtl/fat32_cluster_chain_block_sequencer.sv @@
// ----------------------------------------------------------------------------
// fat32_cluster_chain_block_sequencer
// Walks a FAT32 cluster chain and produces data and table block addresses.
//
//  channel   handshake               payload
//  in        in_valid / in_ready     action, cluster_number, block_in_cluster,
//                                    fat_entry
//  out       out_valid / out_ready   kind, lba, entry_index, cluster_now,
//                                    block_now, last
//  cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item per cycle is accepted while the command queue has room; a seek
// that loads a table block yields two results, others one.
// out_valid rises after an input transfer passes the queue, multiply and
// output registers. The output side delivers one result per cycle; a
// stalled output fills the 4-entry command queue and then drops in_ready.
// Reset clears chain state, cache tag and all valid flags; cfg_ready is
// always high.
// ----------------------------------------------------------------------------
module fat32_cluster_chain_block_sequencer #(
	parameter int CLUSTER_BITS = 28
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              action,
	input  logic [27:0]             cluster_number,
	input  logic [7:0]              block_in_cluster,
	input  logic [31:0]             fat_entry,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              kind,
	output logic [31:0]             lba,
	output logic [9:0]              entry_index,
	output logic [CLUSTER_BITS-1:0] cluster_now,
	output logic [7:0]              block_now,
	output logic                    last,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [31:0]             cfg_data
);

	fccb_pkg::cfg_t cfg_q;
	fccb_pkg::cmd_t push_cmd;
	fccb_pkg::cmd_t head_cmd;
	fccb_pkg::res_t res;
	logic           q_push;
	logic           q_full;
	logic           q_valid;
	logic           q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fat_start    <= fccb_pkg::FAT_START_RST;
			cfg_q.data_start   <= fccb_pkg::DATA_START_RST;
			cfg_q.cluster_size <= fccb_pkg::CLUSTER_SIZE_RST;
			cfg_q.entries_log2 <= fccb_pkg::ENTRIES_LOG2_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (fccb_pkg::cfg_idx_t'(cfg_index))
				fccb_pkg::REG_FAT_START:    cfg_q.fat_start    <= cfg_data;
				fccb_pkg::REG_DATA_START:   cfg_q.data_start   <= cfg_data;
				fccb_pkg::REG_CLUSTER_SIZE: cfg_q.cluster_size <= cfg_data[7:0];
				fccb_pkg::REG_ENTRIES_LOG2: cfg_q.entries_log2 <= cfg_data[3:0];
			endcase
		end
	end

	fccb_front #(
		.CLUSTER_BITS(CLUSTER_BITS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.action           (action),
		.cluster_number   (cluster_number),
		.block_in_cluster (block_in_cluster),
		.fat_entry        (fat_entry),
		.q_full           (q_full),
		.push             (q_push),
		.cmd              (push_cmd)
	);

	fccb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.q_valid  (q_valid),
		.pop      (q_pop),
		.head     (head_cmd)
	);

	fccb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_cmd     (head_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign kind        = res.kind;
	assign lba         = res.lba;
	assign entry_index = res.idx;
	assign cluster_now = CLUSTER_BITS'(res.cluster);
	assign block_now   = res.blk;
	assign last        = res.last;

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("command pushed into full queue");

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("command popped from empty queue");

	a_load_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == fccb_pkg::KIND_LOAD) |-> !last)
		else $error("table load marked as final result");

	a_load_then_seek: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=>
		(out_valid && last && kind == fccb_pkg::KIND_SEEK_DONE))
		else $error("table load not followed by seek done");

endmodule
